@@ rtl/core/wrws_pkg.sv @@
// Shared types, codes and defaults for the window roulette wheel sampler.
package wrws_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int COORD_BITS    = 6;
    localparam int IN_WEIGHT_BITS = 16;
    localparam int FRAC_BITS     = 16;
    localparam int ADDR_BITS     = 4;
    localparam int DATA_BITS     = 32;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_DRAW  = 1'b1;

    localparam logic [1:0] REG_X_LOW  = 2'd0;
    localparam logic [1:0] REG_X_HIGH = 2'd1;
    localparam logic [1:0] REG_Y_LOW  = 2'd2;
    localparam logic [1:0] REG_Y_HIGH = 2'd3;

    localparam logic [COORD_BITS-1:0] X_LOW_RESET  = 6'd0;
    localparam logic [COORD_BITS-1:0] X_HIGH_RESET = 6'd63;
    localparam logic [COORD_BITS-1:0] Y_LOW_RESET  = 6'd0;
    localparam logic [COORD_BITS-1:0] Y_HIGH_RESET = 6'd63;

    typedef struct packed {
        logic                      req_type;
        logic [COORD_BITS-1:0]     cell_x;
        logic [COORD_BITS-1:0]     cell_y;
        logic [IN_WEIGHT_BITS-1:0] cell_weight;
        logic [FRAC_BITS-1:0]      rand_fraction;
    } req_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pick_x;
        logic [COORD_BITS-1:0] pick_y;
    } res_t;

endpackage

@@ rtl/core/window_roulette_wheel_sampler_top.sv @@
// Top level of the window roulette wheel sampler: weight store, window scan and pick logic.
//
//  Channel   Direction  Handshake                   Beat contents
//  -------   ---------  --------------------------  ------------------------------------
//  req       in         start high while busy low   write one weight or draw one sample
//  result    out        done high for one cycle     column and row of the picked cell
//  apb       in/out     psel, penable, pready       window bounds (four 6-bit registers)
//
// A write beat leaves busy low, so the block can take another beat at once.
// A draw beat keeps busy high while it works over a window of Nx columns
// and Ny rows. The weight memory has a single read port: one cell is read
// per cycle while the window total is summed, then one row total per cycle
// from the row-total memory, then one cell per cycle along the chosen row
// until the pick is found. After reset the block sweeps all
// 2**(clog2(GRID_WIDTH)+clog2(GRID_HEIGHT)) entries of the weight memory
// (4096 by default) to zero, one entry per cycle, and holds busy high
// meanwhile; register writes are taken at any time.
// The receiver cannot stall: a result is shown for exactly one cycle with done.
module window_roulette_wheel_sampler_top #(
    parameter int GRID_WIDTH  = wrws_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = wrws_pkg::GRID_HEIGHT_DEF,
    parameter int WEIGHT_BITS = wrws_pkg::WEIGHT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wrws_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [wrws_pkg::DATA_BITS-1:0]   pwdata,
    output logic [wrws_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready,
    input  logic                             start,
    input  wrws_pkg::req_t                   req,
    output logic                             busy,
    output logic                             done,
    output wrws_pkg::res_t                   result
);

    // Address widths of the grid; the weight memory is addressed by {row, column}.
    localparam int XW        = $clog2(GRID_WIDTH);
    localparam int YW        = $clog2(GRID_HEIGHT);
    localparam int AW        = XW + YW;
    localparam int MEM_DEPTH = 2 ** AW;
    localparam int ROW_DEPTH = 2 ** YW;
    // A row sum needs room for GRID_WIDTH weights, the window total for every cell.
    localparam int RW        = WEIGHT_BITS + XW;
    localparam int TW        = WEIGHT_BITS + AW;
    // The threshold product is split into two partial products of about half width.
    localparam int LH        = TW / 2;
    localparam int HH        = TW - LH;
    localparam int FB        = wrws_pkg::FRAC_BITS;
    localparam int CB        = wrws_pkg::COORD_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_THR   = 3'd4;
    localparam logic [2:0] S_ROW   = 3'd5;
    localparam logic [2:0] S_COL   = 3'd6;

    // Window bound registers, written over the register port.
    logic [CB-1:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;

    // Control registers.
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          iss_reg, iss_next;
    logic          dv_reg, dv_next;
    logic          done_reg, done_next;

    // Datapath registers.
    logic [XW-1:0]    cx_reg, cx_next;
    logic [YW-1:0]    cy_reg, cy_next;
    logic [XW-1:0]    d_x_reg, d_x_next;
    logic [YW-1:0]    d_y_reg, d_y_next;
    logic             d_lastx_reg, d_lastx_next;
    logic             d_lasty_reg, d_lasty_next;
    logic [FB-1:0]    frac_reg, frac_next;
    logic [RW-1:0]    acc_reg, acc_next;
    logic [TW-1:0]    total_reg, total_next;
    logic [LH+FB-1:0] prod_lo_reg, prod_lo_next;
    logic [HH+FB-1:0] prod_hi_reg, prod_hi_next;
    logic [TW-1:0]    thr_reg, thr_next;
    logic [TW-1:0]    run_reg, run_next;
    logic [TW-1:0]    rest_reg, rest_next;
    logic [XW-1:0]    pick_x_reg, pick_x_next;
    logic [YW-1:0]    pick_y_reg, pick_y_next;

    // Memories and their ports.
    logic [WEIGHT_BITS-1:0] wmem [MEM_DEPTH];
    logic [RW-1:0]          rmem [ROW_DEPTH];
    logic [WEIGHT_BITS-1:0] wq_reg;
    logic [RW-1:0]          rq_reg;
    logic                   w_we, w_re, r_we, r_re;
    logic [AW-1:0]          w_waddr, w_raddr;
    logic [WEIGHT_BITS-1:0] w_wdata;
    logic [YW-1:0]          r_waddr, r_raddr;
    logic [RW-1:0]          r_wdata;

    // Clamped window bounds.
    logic [XW-1:0] xl, xh_c, xh;
    logic [YW-1:0] yl, yh_c, yh;

    logic             cfg_we;
    logic             in_grid;
    logic [RW-1:0]    row_sum;
    logic [TW-1:0]    run_row, run_col;
    logic [TW+FB-1:0] prod_sum;

    // ------------------------------------------------------------------
    // Register port. pready is held high, so every access completes without wait states.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg  <= wrws_pkg::X_LOW_RESET;
            x_high_reg <= wrws_pkg::X_HIGH_RESET;
            y_low_reg  <= wrws_pkg::Y_LOW_RESET;
            y_high_reg <= wrws_pkg::Y_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                wrws_pkg::REG_X_LOW:  x_low_reg  <= pwdata[CB-1:0];
                wrws_pkg::REG_X_HIGH: x_high_reg <= pwdata[CB-1:0];
                wrws_pkg::REG_Y_LOW:  y_low_reg  <= pwdata[CB-1:0];
                wrws_pkg::REG_Y_HIGH: y_high_reg <= pwdata[CB-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            wrws_pkg::REG_X_LOW:  prdata = 32'(x_low_reg);
            wrws_pkg::REG_X_HIGH: prdata = 32'(x_high_reg);
            wrws_pkg::REG_Y_LOW:  prdata = 32'(y_low_reg);
            wrws_pkg::REG_Y_HIGH: prdata = 32'(y_high_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Window bounds: each bound is clamped to the grid, and a high bound
    // below its low bound is raised to it.
    // ------------------------------------------------------------------
    always_comb
    begin
        xl   = (32'(x_low_reg) > 32'(GRID_WIDTH - 1)) ? XW'(GRID_WIDTH - 1) : XW'(x_low_reg);
        xh_c = (32'(x_high_reg) > 32'(GRID_WIDTH - 1)) ? XW'(GRID_WIDTH - 1) : XW'(x_high_reg);
        yl   = (32'(y_low_reg) > 32'(GRID_HEIGHT - 1)) ? YW'(GRID_HEIGHT - 1) : YW'(y_low_reg);
        yh_c = (32'(y_high_reg) > 32'(GRID_HEIGHT - 1)) ? YW'(GRID_HEIGHT - 1)
                                                        : YW'(y_high_reg);
        xh   = (xh_c < xl) ? xl : xh_c;
        yh   = (yh_c < yl) ? yl : yh_c;
    end

    // A write outside the grid is dropped.
    assign in_grid = (32'(req.cell_x) < 32'(GRID_WIDTH)) && (32'(req.cell_y) < 32'(GRID_HEIGHT));

    // Running sums fed by the registered memory outputs.
    assign row_sum  = acc_reg + RW'(wq_reg);
    assign run_row  = run_reg + TW'(rq_reg);
    assign run_col  = run_reg + TW'(wq_reg);
    // Recombined threshold product, total * fraction; its top TW bits are the threshold.
    assign prod_sum = ((TW + FB)'(prod_hi_reg) << LH) + (TW + FB)'(prod_lo_reg);

    // ------------------------------------------------------------------
    // Sequencer. Each read's data arrives in the cycle after it is issued; the dv
    // flag and the d_* registers travel with each read to its data cycle.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        iss_next     = iss_reg;
        dv_next      = 1'b0;
        done_next    = 1'b0;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        d_x_next     = d_x_reg;
        d_y_next     = d_y_reg;
        d_lastx_next = d_lastx_reg;
        d_lasty_next = d_lasty_reg;
        frac_next    = frac_reg;
        acc_next     = acc_reg;
        total_next   = total_reg;
        prod_lo_next = prod_lo_reg;
        prod_hi_next = prod_hi_reg;
        thr_next     = thr_reg;
        run_next     = run_reg;
        rest_next    = rest_reg;
        pick_x_next  = pick_x_reg;
        pick_y_next  = pick_y_reg;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = '0;
        r_we         = 1'b0;
        r_waddr      = '0;
        r_wdata      = '0;
        r_re         = 1'b0;
        r_raddr      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                w_we         = 1'b1;
                w_waddr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    if (req.req_type == wrws_pkg::REQ_WRITE)
                    begin
                        w_we    = in_grid;
                        w_waddr = {YW'(req.cell_y), XW'(req.cell_x)};
                        w_wdata = WEIGHT_BITS'(req.cell_weight);
                    end
                    else
                    begin
                        frac_next  = req.rand_fraction;
                        cx_next    = xl;
                        cy_next    = yl;
                        iss_next   = 1'b1;
                        acc_next   = '0;
                        total_next = '0;
                        state_next = S_SUM;
                    end
                end
            end

            // Sum the window row by row; each row total is kept in the row memory.
            S_SUM:
            begin
                if (iss_reg)
                begin
                    w_re         = 1'b1;
                    w_raddr      = {cy_reg, cx_reg};
                    dv_next      = 1'b1;
                    d_lastx_next = (cx_reg == xh);
                    d_lasty_next = (cy_reg == yh);
                    d_y_next     = cy_reg;
                    if (cx_reg == xh)
                    begin
                        cx_next = xl;
                        if (cy_reg == yh)
                        begin
                            iss_next = 1'b0;
                        end
                        else
                        begin
                            cy_next = cy_reg + YW'(1);
                        end
                    end
                    else
                    begin
                        cx_next = cx_reg + XW'(1);
                    end
                end
                if (dv_reg)
                begin
                    if (d_lastx_reg)
                    begin
                        r_we       = 1'b1;
                        r_waddr    = d_y_reg;
                        r_wdata    = row_sum;
                        total_next = total_reg + TW'(row_sum);
                        acc_next   = '0;
                        if (d_lasty_reg)
                        begin
                            state_next = S_MUL;
                        end
                    end
                    else
                    begin
                        acc_next = row_sum;
                    end
                end
            end

            S_MUL:
            begin
                prod_lo_next = (LH + FB)'(total_reg[LH-1:0]) * (LH + FB)'(frac_reg);
                prod_hi_next = (HH + FB)'(total_reg[TW-1:LH]) * (HH + FB)'(frac_reg);
                state_next   = S_THR;
            end

            S_THR:
            begin
                thr_next   = prod_sum[TW+FB-1:FB];
                cy_next    = yl;
                iss_next   = 1'b1;
                run_next   = '0;
                state_next = S_ROW;
            end

            // Find the first row whose running total reaches the threshold, else the last row.
            S_ROW:
            begin
                if (iss_reg)
                begin
                    r_re         = 1'b1;
                    r_raddr      = cy_reg;
                    dv_next      = 1'b1;
                    d_lasty_next = (cy_reg == yh);
                    d_y_next     = cy_reg;
                    if (cy_reg == yh)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        cy_next = cy_reg + YW'(1);
                    end
                end
                if (dv_reg)
                begin
                    if ((run_row >= thr_reg) || d_lasty_reg)
                    begin
                        if (run_row >= thr_reg)
                        begin
                            pick_y_next = d_y_reg;
                            rest_next   = thr_reg - run_reg;
                        end
                        else
                        begin
                            pick_y_next = yh;
                            rest_next   = thr_reg;
                        end
                        cx_next    = xl;
                        iss_next   = 1'b1;
                        dv_next    = 1'b0;
                        run_next   = '0;
                        state_next = S_COL;
                    end
                    else
                    begin
                        run_next = run_row;
                    end
                end
            end

            // Walk the chosen row until the running sum reaches the remainder or the row ends.
            S_COL:
            begin
                if (iss_reg)
                begin
                    w_re         = 1'b1;
                    w_raddr      = {pick_y_reg, cx_reg};
                    dv_next      = 1'b1;
                    d_lastx_next = (cx_reg == xh);
                    d_x_next     = cx_reg;
                    if (cx_reg == xh)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        cx_next = cx_reg + XW'(1);
                    end
                end
                if (dv_reg)
                begin
                    if ((run_col >= rest_reg) || d_lastx_reg)
                    begin
                        pick_x_next = (run_col >= rest_reg) ? d_x_reg : xh;
                        iss_next    = 1'b0;
                        dv_next     = 1'b0;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        run_next = run_col;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
                iss_next   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            iss_reg     <= 1'b0;
            dv_reg      <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            iss_reg     <= iss_next;
            dv_reg      <= dv_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        d_x_reg     <= d_x_next;
        d_y_reg     <= d_y_next;
        d_lastx_reg <= d_lastx_next;
        d_lasty_reg <= d_lasty_next;
        frac_reg    <= frac_next;
        acc_reg     <= acc_next;
        total_reg   <= total_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        thr_reg     <= thr_next;
        run_reg     <= run_next;
        rest_reg    <= rest_next;
        pick_x_reg  <= pick_x_next;
        pick_y_reg  <= pick_y_next;
    end

    // Weight memory: one port, since writes and reads never fall in the same cycle.
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[w_waddr] <= w_wdata;
        end
        if (w_re)
        begin
            wq_reg <= wmem[w_raddr];
        end
    end

    // Row-total memory, refilled by every draw for the rows of its window.
    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            rmem[r_waddr] <= r_wdata;
        end
        if (r_re)
        begin
            rq_reg <= rmem[r_raddr];
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign result.pick_x = CB'(pick_x_reg);
    assign result.pick_y = CB'(pick_y_reg);

endmodule

@@ rtl/core/wrws_checker.sv @@
// Port-level checks for the window roulette wheel sampler, bound to its top level.
module wrws_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input wrws_pkg::req_t req,
    input logic           busy,
    input logic           done
);

    // A draw beat that is taken must be followed by busy high.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type == wrws_pkg::REQ_DRAW)) |=> busy)
        else $error("draw beat accepted but block not busy afterwards");

    // A write finishes at once and yields no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type == wrws_pkg::REQ_WRITE)) |=> (!busy && !done))
        else $error("write beat left the block busy or produced a result");

    // A result only comes at the end of a draw in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe outside the end of a draw");

    // Results are single-cycle strobes.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind window_roulette_wheel_sampler_top wrws_checker u_wrws_checker (.*);

@@ sim/tb_window_roulette_wheel_sampler_top.sv @@
// Self-checking testbench for the window roulette wheel sampler top level.
module tb_window_roulette_wheel_sampler_top;

    timeunit 1ns;
    timeprecision 1ps;

    import wrws_pkg::*;

    // The grid is 64 x 64 with 6-bit coordinates, so the clamp of window bounds
    // to the grid never changes a value and a write can never fall outside it.
    localparam int GRID_W  = GRID_WIDTH_DEF;
    localparam int GRID_H  = GRID_HEIGHT_DEF;
    localparam int CELL_AW = $clog2(GRID_W * GRID_H);

    // Neither a full-window draw nor the clearing sweep after reset comes near
    // STALL_LIMIT, so reaching it with no accepted beat, no result and no
    // register access can only mean the block has hung.
    localparam int STALL_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 start;
    req_t                 req;
    logic                 busy;
    logic                 done;
    res_t                 result;

    // Our own copy of the block's state: the weight grid (row major, y*64 + x)
    // and the four window bounds as last written.
    logic [WEIGHT_BITS_DEF-1:0] weight_model [0:GRID_W*GRID_H-1];
    logic [COORD_BITS-1:0]      win_x_lo;
    logic [COORD_BITS-1:0]      win_x_hi;
    logic [COORD_BITS-1:0]      win_y_lo;
    logic [COORD_BITS-1:0]      win_y_hi;

    // Picks predicted for accepted draw beats, oldest first.
    res_t pending_picks [$];

    int fail_count    = 0;
    int check_fails   = 0;
    int beats_sent    = 0;
    int picks_checked = 0;
    int windows_set   = 0;
    int burst_left    = 1;
    int stall_cycles  = 0;

    window_roulette_wheel_sampler_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sum of one row of the window, wide enough that nothing can overflow.
    function automatic longint row_weight(input int y, input int xl, input int xh);
        longint sum;
        sum = 0;
        for (int x = xl; x <= xh; x++)
            sum += longint'(weight_model[CELL_AW'(y*GRID_W + x)]);
        return sum;
    endfunction

    // Works out which cell a draw with the given fraction selects. The window
    // total is scaled to a threshold in two halves so the product stays exact;
    // the row search and then the column search both stop at the first running
    // sum that is greater than or equal to what is left of the threshold.
    function automatic res_t predict_pick(input logic [FRAC_BITS-1:0] frac);
        int     xl, xh, yl, yh, px, py;
        longint total, thr, run, rest, row_sum;
        res_t   pick;
        xl = int'(win_x_lo);
        xh = int'(win_x_hi);
        yl = int'(win_y_lo);
        yh = int'(win_y_hi);
        // A high bound below its low bound collapses that axis to one line.
        if (xh < xl)
            xh = xl;
        if (yh < yl)
            yh = yl;
        total = 0;
        for (int y = yl; y <= yh; y++)
            total += row_weight(y, xl, xh);
        thr = (total >> 16) * longint'(frac) + (((total & 64'hFFFF) * longint'(frac)) >> 16);
        py   = yh;
        run  = 0;
        rest = thr;
        for (int y = yl; y <= yh; y++)
        begin
            row_sum = row_weight(y, xl, xh);
            if (run + row_sum >= thr)
            begin
                py   = y;
                rest = thr - run;
                break;
            end
            run += row_sum;
        end
        px  = xh;
        run = 0;
        for (int x = xl; x <= xh; x++)
        begin
            run += longint'(weight_model[CELL_AW'(py*GRID_W + x)]);
            if (run >= rest)
            begin
                px = x;
                break;
            end
        end
        pick.pick_x = px[COORD_BITS-1:0];
        pick.pick_y = py[COORD_BITS-1:0];
        return pick;
    endfunction

    // A write beat carries a random fraction, which the block must ignore.
    function automatic req_t write_beat(input int x, input int y, input int w);
        req_t beat;
        beat.req_type      = REQ_WRITE;
        beat.cell_x        = x[COORD_BITS-1:0];
        beat.cell_y        = y[COORD_BITS-1:0];
        beat.cell_weight   = w[IN_WEIGHT_BITS-1:0];
        beat.rand_fraction = FRAC_BITS'($urandom_range(0, 65535));
        return beat;
    endfunction

    // A draw beat carries random cell fields, which the block must ignore.
    function automatic req_t draw_beat(input int frac);
        req_t beat;
        beat.req_type      = REQ_DRAW;
        beat.cell_x        = COORD_BITS'($urandom_range(0, 63));
        beat.cell_y        = COORD_BITS'($urandom_range(0, 63));
        beat.cell_weight   = IN_WEIGHT_BITS'($urandom_range(0, 65535));
        beat.rand_fraction = frac[FRAC_BITS-1:0];
        return beat;
    endfunction

    // Offers one beat and holds it until the block takes it (start high while
    // busy low at a rising edge). Handshake signals are sampled right after the
    // edge, before any nonblocking update, so we see what the block saw. Once
    // taken, the beat updates our grid or queues its predicted pick. The sender
    // then either keeps start high for the next beat of the burst or drops it
    // for a random gap; start is never lowered and raised in the same step.
    task automatic send_beat(input req_t beat);
        start <= 1'b1;
        req   <= beat;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
        if (beat.req_type == REQ_WRITE)
            weight_model[{beat.cell_y, beat.cell_x}] = beat.cell_weight;
        else
            pending_picks.insert(pending_picks.size(), predict_pick(beat.rand_fraction));
        burst_left--;
        if (burst_left <= 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            // Now and then a long burst, so runs with no idling occur too.
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 6);
        end
    endtask

    // Stops sending, then waits until every predicted pick has come back and
    // the block has dropped busy, then idles on before it returns.
    task automatic drain_block();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_picks.size() != 0 || busy);
        repeat (8)
            @(posedge clk);
    endtask

    // One register transfer: a setup phase, then an access phase that ends at
    // the edge where pready is seen high. The bus is then left idle so that
    // back-to-back transfers never drive psel twice in one step.
    task automatic apb_access(input logic is_write, input logic [1:0] idx,
                              input logic [DATA_BITS-1:0] wdata,
                              output logic [DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_window_reg(input logic [1:0] idx, input logic [COORD_BITS-1:0] want);
        logic [DATA_BITS-1:0] rdata;
        apb_access(1'b0, idx, '0, rdata);
        if (rdata !== DATA_BITS'(want))
        begin
            $error("prdata of register %0d: expected %0d, actual %0d", idx, want, rdata);
            fail_count++;
        end
    endtask

    // Writes all four window bounds while the block is idle, mirrors them in
    // our copy, and reads each one back.
    task automatic set_window(input int xl, input int xh, input int yl, input int yh);
        logic [DATA_BITS-1:0] rdata;
        drain_block();
        apb_access(1'b1, REG_X_LOW,  DATA_BITS'(xl), rdata);
        apb_access(1'b1, REG_X_HIGH, DATA_BITS'(xh), rdata);
        apb_access(1'b1, REG_Y_LOW,  DATA_BITS'(yl), rdata);
        apb_access(1'b1, REG_Y_HIGH, DATA_BITS'(yh), rdata);
        win_x_lo = xl[COORD_BITS-1:0];
        win_x_hi = xh[COORD_BITS-1:0];
        win_y_lo = yl[COORD_BITS-1:0];
        win_y_hi = yh[COORD_BITS-1:0];
        check_window_reg(REG_X_LOW,  win_x_lo);
        check_window_reg(REG_X_HIGH, win_x_hi);
        check_window_reg(REG_Y_LOW,  win_y_lo);
        check_window_reg(REG_Y_HIGH, win_y_hi);
        windows_set++;
    endtask

    // Reset values of the bounds, then draws on an all-zero grid over the full
    // window: whatever the fraction, the threshold is zero and the first cell
    // of the window is picked. The first beat waits out the clearing sweep.
    task automatic test_reset_state();
        check_window_reg(REG_X_LOW,  X_LOW_RESET);
        check_window_reg(REG_X_HIGH, X_HIGH_RESET);
        check_window_reg(REG_Y_LOW,  Y_LOW_RESET);
        check_window_reg(REG_Y_HIGH, Y_HIGH_RESET);
        send_beat(draw_beat(0));
        send_beat(draw_beat(65535));
    endtask

    // Extreme weights at the grid corners over the full window. A zero
    // threshold lands on the zero-weight corner cell; a large fraction has to
    // walk the whole grid to reach the last cell.
    task automatic test_weight_extremes();
        send_beat(write_beat(63, 63, 65535));
        send_beat(write_beat(0, 0, 0));
        send_beat(draw_beat(0));
        send_beat(draw_beat(65535));
        send_beat(draw_beat(32768));
    endtask

    // Window shapes: a corner block, inverted bounds that collapse to the last
    // cell, a single cell at the origin, and a short row with zero weights in
    // it where a zero threshold must stop on a zero-weight cell.
    task automatic test_window_bounds();
        set_window(60, 63, 60, 63);
        send_beat(write_beat(61, 60, 1));
        send_beat(write_beat(62, 61, 65535));
        send_beat(draw_beat(0));
        send_beat(draw_beat(65535));
        set_window(63, 0, 63, 0);
        send_beat(draw_beat($urandom_range(0, 65535)));
        set_window(0, 0, 0, 0);
        send_beat(draw_beat($urandom_range(0, 65535)));
        set_window(10, 13, 20, 20);
        send_beat(write_beat(11, 20, 3));
        send_beat(write_beat(13, 20, 3));
        send_beat(draw_beat(0));
        send_beat(draw_beat(32768));
        send_beat(draw_beat(65535));
    endtask

    // Random traffic in phases, each with its own window: one wider window,
    // several small ones so draws stay short, and a last one with the high
    // bounds at or below the low bounds. Most writes land inside the window so
    // the draws see varied weights; the rest go anywhere on the grid.
    task automatic test_random_traffic();
        int xl, xh, yl, yh, span, x, y, w, frac;
        for (int phase = 0; phase < 5; phase++)
        begin
            span = (phase == 0) ? 15 : $urandom_range(0, 7);
            xl   = $urandom_range(0, 63);
            yl   = $urandom_range(0, 63);
            xh   = (xl + span > 63) ? 63 : xl + span;
            yh   = (yl + span > 63) ? 63 : yl + span;
            if (phase == 4)
            begin
                xh = $urandom_range(0, xl);
                yh = $urandom_range(0, yl);
            end
            set_window(xl, xh, yl, yh);
            if (xh < xl)
                xh = xl;
            if (yh < yl)
                yh = yl;
            repeat (20)
            begin
                if ($urandom_range(0, 99) < 55)
                begin
                    if ($urandom_range(0, 6) == 0)
                    begin
                        x = $urandom_range(0, 63);
                        y = $urandom_range(0, 63);
                    end
                    else
                    begin
                        x = $urandom_range(xl, xh);
                        y = $urandom_range(yl, yh);
                    end
                    case ($urandom_range(0, 3))
                        0:       w = 0;
                        1:       w = 65535;
                        2:       w = $urandom_range(1, 15);
                        default: w = $urandom_range(0, 65535);
                    endcase
                    send_beat(write_beat(x, y, w));
                end
                else
                begin
                    case ($urandom_range(0, 4))
                        0:       frac = 0;
                        1:       frac = 65535;
                        default: frac = $urandom_range(0, 65535);
                    endcase
                    send_beat(draw_beat(frac));
                end
            end
        end
    endtask

    // Every result beat is compared with the oldest predicted pick. Results
    // cannot be held off, so done and result are sampled at the edge that ends
    // their one valid cycle.
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && done)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("result with no draw pending: pick_x %0d, pick_y %0d",
                       result.pick_x, result.pick_y);
                check_fails++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (result.pick_x !== want.pick_x)
                begin
                    $error("pick_x: expected %0d, actual %0d", want.pick_x, result.pick_x);
                    check_fails++;
                end
                if (result.pick_y !== want.pick_y)
                begin
                    $error("pick_y: expected %0d, actual %0d", want.pick_y, result.pick_y);
                    check_fails++;
                end
                picks_checked++;
            end
        end
    end

    // Watchdog: any accepted beat, result or register access restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[window_roulette_wheel_sampler_top] ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        // Every input is known from time zero, while reset is held low at first.
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        start   = 1'b0;
        req     = '0;
        for (int i = 0; i < GRID_W*GRID_H; i++)
            weight_model[CELL_AW'(i)] = '0;
        win_x_lo = X_LOW_RESET;
        win_x_hi = X_HIGH_RESET;
        win_y_lo = Y_LOW_RESET;
        win_y_hi = Y_HIGH_RESET;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_weight_extremes();
        test_window_bounds();
        test_random_traffic();
        drain_block();

        if (pending_picks.size() != 0)
        begin
            $error("%0d predicted picks never arrived", pending_picks.size());
            fail_count++;
        end
        $display("Sent %0d beats and checked %0d picks over %0d window settings,",
                 beats_sent, picks_checked, windows_set);
        $display("including empty-grid, corner, inverted-bound and single-cell windows.");
        if (fail_count + check_fails == 0)
            $display("[window_roulette_wheel_sampler_top] OK");
        else
            $display("[window_roulette_wheel_sampler_top] ERROR");
        $finish;
    end

endmodule
